// ===== hdl/abu_pkg.sv =====
// ----------------------------------------------------------------------------
// abu_pkg
// Types and constants shared by the absorbing boundary update block.
// ----------------------------------------------------------------------------
`default_nettype none

package abu_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int NODE_W     = 12;
    localparam int NODES      = 1 << NODE_W;
    localparam int ALPHA_W    = 16;
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = ALPHA_W + DIFF_W;
    localparam int RND_W  = PROD_W + 1 - FRAC_BITS;
    localparam int SUM_W  = RND_W + 1;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [NODE_W-1:0]   node_t;
    typedef logic signed [ALPHA_W-1:0]  alpha_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic        [ADDR_W-3:0]   reg_idx_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam reg_idx_t REG_ALPHA = reg_idx_t'(0);

    // one history entry: old boundary and old inner values of both components
    typedef struct packed {
        sample_t bnd_p;
        sample_t bnd_q;
        sample_t inr_p;
        sample_t inr_q;
    } hist_t;

    // pipeline control shared by both lanes
    typedef struct packed {
        logic en;
        logic op;
    } lane_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/abu_if.sv =====
// ----------------------------------------------------------------------------
// abu_in_if / abu_out_if
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface abu_in_if;
    import abu_pkg::*;

    logic    valid;
    logic    ready;
    logic    op;
    node_t   node;
    sample_t boundary_p;
    sample_t boundary_q;
    sample_t inner_p;
    sample_t inner_q;

    modport source (
        output valid, op, node, boundary_p, boundary_q, inner_p, inner_q,
        input  ready
    );

    modport sink (
        input  valid, op, node, boundary_p, boundary_q, inner_p, inner_q,
        output ready
    );
endinterface

interface abu_out_if;
    import abu_pkg::*;

    logic    valid;
    logic    ready;
    node_t   node_out;
    sample_t new_boundary_p;
    sample_t new_boundary_q;

    modport source (
        output valid, node_out, new_boundary_p, new_boundary_q,
        input  ready
    );

    modport sink (
        input  valid, node_out, new_boundary_p, new_boundary_q,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/abu_lane.sv =====
// ----------------------------------------------------------------------------
// abu_lane
// Three-stage arithmetic for one field component: difference, Q1.15
// multiply, then round, add and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module abu_lane (
    input  wire logic               clk,
    input  wire abu_pkg::lane_ctl_t ctl,
    input  wire abu_pkg::alpha_t    alpha,
    input  wire abu_pkg::sample_t   inner,
    input  wire abu_pkg::sample_t   boundary,
    input  wire abu_pkg::sample_t   old_b,
    input  wire abu_pkg::sample_t   old_i,
    output abu_pkg::sample_t        new_val
);
    import abu_pkg::*;

    diff_t   d_next;
    diff_t   d_reg;
    sample_t oi_b_reg;
    sample_t bnd_b_reg;
    prod_t   alpha_ext;
    prod_t   d_ext;
    prod_t   m_next;
    prod_t   m_reg;
    sample_t oi_c_reg;
    sample_t bnd_c_reg;

    logic signed [PROD_W:0]  m_rnd;
    logic signed [RND_W-1:0] rnd;
    logic signed [SUM_W-1:0] sum;
    logic                    ovf;
    sample_t                 sat;

    assign d_next    = DIFF_W'(inner) - DIFF_W'(old_b);
    assign alpha_ext = PROD_W'(alpha);
    assign d_ext     = PROD_W'(d_reg);
    assign m_next    = alpha_ext * d_ext;

    // floor((m + half) / 2^FRAC_BITS)
    assign m_rnd = (PROD_W+1)'(m_reg) + (PROD_W+1)'(ROUND_HALF);
    assign rnd   = m_rnd[PROD_W:FRAC_BITS];
    assign sum   = SUM_W'(oi_c_reg) + SUM_W'(rnd);
    assign ovf   = (sum[SUM_W-1:SAMPLE_W-1] != {(SUM_W-SAMPLE_W+1){sum[SUM_W-1]}});

    always_comb
    begin
        if (ovf)
        begin
            sat = sum[SUM_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
        else
        begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    assign new_val = (ctl.op == OP_UPDATE) ? sat : bnd_c_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            d_reg     <= d_next;
            oi_b_reg  <= old_i;
            bnd_b_reg <= boundary;
            m_reg     <= m_next;
            oi_c_reg  <= oi_b_reg;
            bnd_c_reg <= bnd_b_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/absorbing_boundary_update.sv =====
// ----------------------------------------------------------------------------
// absorbing_boundary_update
// First-order absorbing boundary update of the two tangential E components
// of one boundary node per item, with a per-node history memory.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       contents
//  din      in   valid/ready     op, node, boundary_p/q, inner_p/q
//  dout     out  valid/ready     node_out, new_boundary_p/q
//  apb      in   psel/penable    alpha register at byte address 0
//
//  One item per cycle unless a hazard or a full skid holds din back.
//  An update whose node matches one of the two items ahead of it waits:
//  the history loop runs through the multiply stage.
//  Reset clears valid bits and alpha; the history memory is not cleared.
//  A one-entry skid behind the output register keeps din ready while a
//  result waits; ready drops once the skid is full.
// ----------------------------------------------------------------------------
`default_nettype none

module absorbing_boundary_update (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    abu_in_if.sink                     din,
    abu_out_if.source                  dout,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [abu_pkg::ADDR_W-1:0] paddr,
    input  wire logic [abu_pkg::DATA_W-1:0] pwdata,
    output logic      [abu_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import abu_pkg::*;

    alpha_t   alpha_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    logic     en;
    logic     hazard;
    logic     accept;

    logic     a_valid_reg;
    logic     a_op_reg;
    node_t    a_node_reg;
    sample_t  a_inner_p_reg;
    sample_t  a_inner_q_reg;
    sample_t  a_bnd_p_reg;
    sample_t  a_bnd_q_reg;

    logic     b_valid_reg;
    logic     b_op_reg;
    node_t    b_node_reg;
    sample_t  b_inner_p_reg;
    sample_t  b_inner_q_reg;

    logic     c_valid_reg;
    logic     c_op_reg;
    node_t    c_node_reg;
    sample_t  c_inner_p_reg;
    sample_t  c_inner_q_reg;

    hist_t    mem [NODES];
    hist_t    rdata_reg;
    hist_t    a_hist;
    hist_t    wr_data;

    logic     wf_valid_reg;
    node_t    wf_node_reg;
    hist_t    wf_data_reg;

    lane_ctl_t lane_ctl;
    sample_t   new_p;
    sample_t   new_q;

    logic     d_valid_reg;
    node_t    d_node_reg;
    sample_t  d_p_reg;
    sample_t  d_q_reg;
    logic     s_valid_reg;
    node_t    s_node_reg;
    sample_t  s_p_reg;
    sample_t  s_q_reg;
    logic     pop;
    logic     push;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb
    begin
        case (reg_idx)
            REG_ALPHA: prdata = DATA_W'(alpha_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
        end
        else if (cfg_wr && (reg_idx == REG_ALPHA))
        begin
            alpha_reg <= alpha_t'(pwdata[ALPHA_W-1:0]);
        end
    end

    // pipeline control
    assign en     = !s_valid_reg;
    assign hazard = din.valid && (din.op == OP_UPDATE) &&
                    ((a_valid_reg && (a_node_reg == din.node)) ||
                     (b_valid_reg && (b_node_reg == din.node)));
    assign din.ready = en & !hazard;
    assign accept    = din.valid & din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            wf_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg  <= accept;
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
            wf_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg      <= din.op;
            a_node_reg    <= din.node;
            a_inner_p_reg <= din.inner_p;
            a_inner_q_reg <= din.inner_q;
            a_bnd_p_reg   <= din.boundary_p;
            a_bnd_q_reg   <= din.boundary_q;
            b_op_reg      <= a_op_reg;
            b_node_reg    <= a_node_reg;
            b_inner_p_reg <= a_inner_p_reg;
            b_inner_q_reg <= a_inner_q_reg;
            c_op_reg      <= b_op_reg;
            c_node_reg    <= b_node_reg;
            c_inner_p_reg <= b_inner_p_reg;
            c_inner_q_reg <= b_inner_q_reg;
            wf_node_reg   <= c_node_reg;
            wf_data_reg   <= wr_data;
        end
    end

    // history memory: read on entry, written as the item leaves stage C
    assign wr_data = '{bnd_p: new_p, bnd_q: new_q,
                       inr_p: c_inner_p_reg, inr_q: c_inner_q_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (c_valid_reg)
            begin
                mem[c_node_reg] <= wr_data;
            end
            rdata_reg <= mem[din.node];
        end
    end

    // the write landing on the read edge is not seen by the read
    assign a_hist = (wf_valid_reg && (wf_node_reg == a_node_reg)) ? wf_data_reg
                                                                  : rdata_reg;

    assign lane_ctl = '{en: en, op: c_op_reg};

    abu_lane u_lane_p (
        .clk      (clk),
        .ctl      (lane_ctl),
        .alpha    (alpha_reg),
        .inner    (a_inner_p_reg),
        .boundary (a_bnd_p_reg),
        .old_b    (a_hist.bnd_p),
        .old_i    (a_hist.inr_p),
        .new_val  (new_p)
    );

    abu_lane u_lane_q (
        .clk      (clk),
        .ctl      (lane_ctl),
        .alpha    (alpha_reg),
        .inner    (a_inner_q_reg),
        .boundary (a_bnd_q_reg),
        .old_b    (a_hist.bnd_q),
        .old_i    (a_hist.inr_q),
        .new_val  (new_q)
    );

    // output register and skid
    assign pop  = d_valid_reg & dout.ready;
    assign push = en & c_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (pop && s_valid_reg)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            d_valid_reg <= push;
        end
        else if (push)
        begin
            if (d_valid_reg)
            begin
                s_valid_reg <= 1'b1;
            end
            else
            begin
                d_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && s_valid_reg)
        begin
            d_node_reg <= s_node_reg;
            d_p_reg    <= s_p_reg;
            d_q_reg    <= s_q_reg;
        end
        else if (push && (pop || !d_valid_reg))
        begin
            d_node_reg <= c_node_reg;
            d_p_reg    <= new_p;
            d_q_reg    <= new_q;
        end

        if (push && d_valid_reg && !pop)
        begin
            s_node_reg <= c_node_reg;
            s_p_reg    <= new_p;
            s_q_reg    <= new_q;
        end
    end

    assign dout.valid          = d_valid_reg;
    assign dout.node_out       = d_node_reg;
    assign dout.new_boundary_p = d_p_reg;
    assign dout.new_boundary_q = d_q_reg;

    // an update never shares its node with an unwritten item ahead of it
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && (a_op_reg == OP_UPDATE) && b_valid_reg)
            |-> (a_node_reg != b_node_reg))
    else $error("update in stage A overtakes pending write in stage B");

    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && (a_op_reg == OP_UPDATE) && c_valid_reg)
            |-> (a_node_reg != c_node_reg))
    else $error("update in stage A overtakes pending write in stage C");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> d_valid_reg)
    else $error("skid holds an item while the output register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> !din.ready)
    else $error("input taken while the skid is full");

endmodule

`default_nettype wire

// ===== tb/absorbing_boundary_update_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// absorbing_boundary_update_tb
// Self-checking bench for the absorbing boundary update block. Load and
// update items go in over the input channel with random gaps. The bench
// keeps its own per-node history and fixed-point rule to predict each
// boundary result. Results are checked in order against that prediction,
// with a random stalling receiver. alpha is set over APB between phases,
// including both extremes, and read back after each write.
// ----------------------------------------------------------------------------
module absorbing_boundary_update_tb;
    import abu_pkg::*;

    localparam int       DRAIN_CYC   = 8;
    localparam int       HOLD_CYC    = 80;
    localparam int       HOLD_AT     = 150;
    localparam int       PHASES      = 5;
    localparam int       PHASE_ITEMS = 80;
    localparam int       POOL_SIZE   = 16;
    localparam int       DIR_ROWS    = 22;
    localparam reg_idx_t REG_UNUSED  = reg_idx_t'(1);
    localparam alpha_t   ALPHA_MAX   = {1'b0, {(ALPHA_W-1){1'b1}}};
    localparam alpha_t   ALPHA_MIN   = {1'b1, {(ALPHA_W-1){1'b0}}};
    localparam alpha_t   ALPHA_ZERO  = '0;

    typedef struct packed {
        logic    op;
        node_t   node;
        sample_t bp;
        sample_t bq;
        sample_t ip;
        sample_t iq;
    } bnd_item_t;

    typedef struct packed {
        node_t   node;
        sample_t p;
        sample_t q;
    } bnd_result_t;

    typedef struct packed {
        alpha_t    alpha;
        bnd_item_t item;
        logic      chk;
        sample_t   ep;
        sample_t   eq;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    abu_in_if  din_if ();
    abu_out_if dout_if ();

    alpha_t      alpha_q = '0;
    hist_t       node_hist [NODES];
    bit          node_loaded [NODES];
    bnd_result_t boundary_due [$];
    int          n_errors = 0;
    int          n_results = 0;
    bit          tail_mode = 1'b0;
    bit          rx_idle = 1'b1;
    bit          hold_done = 1'b0;

    // directed items; chk rows carry a hand-derived expectation
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ALPHA_ZERO, '{OP_LOAD, 12'd0, SAMPLE_MAX, SAMPLE_MIN, 32'sd0, 32'sd0},
          1'b1, SAMPLE_MAX, SAMPLE_MIN},
        '{ALPHA_ZERO, '{OP_LOAD, 12'd4095, -32'sd1, 32'sh12345678, SAMPLE_MAX, SAMPLE_MIN},
          1'b1, -32'sd1, 32'sh12345678},
        '{ALPHA_ZERO, '{OP_UPDATE, 12'd4095, 32'sd0, 32'sd0, 32'sd5, -32'sd5},
          1'b1, SAMPLE_MAX, SAMPLE_MIN},
        '{ALPHA_ZERO, '{OP_UPDATE, 12'd0, 32'sd0, 32'sd0, SAMPLE_MIN, SAMPLE_MAX},
          1'b1, 32'sd0, 32'sd0},
        '{ALPHA_ZERO, '{OP_LOAD, 12'hAAA, 32'sh55555555, 32'shAAAAAAAA, 32'shAAAAAAAA,
          32'sh55555555}, 1'b1, 32'sh55555555, 32'shAAAAAAAA},
        '{ALPHA_MAX, '{OP_LOAD, 12'd1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN},
          1'b1, SAMPLE_MIN, SAMPLE_MAX},
        '{ALPHA_MAX, '{OP_UPDATE, 12'd1, 32'sd0, 32'sd0, SAMPLE_MAX, SAMPLE_MIN},
          1'b1, SAMPLE_MAX, SAMPLE_MIN},
        '{ALPHA_MAX, '{OP_UPDATE, 12'd1, 32'sd0, 32'sd0, SAMPLE_MAX, SAMPLE_MIN},
          1'b1, SAMPLE_MAX, SAMPLE_MIN},
        '{ALPHA_MAX, '{OP_UPDATE, 12'd1, -32'sd1, -32'sd1, 32'sd0, 32'sd0},
          1'b0, 32'sd0, 32'sd0},
        '{ALPHA_MAX, '{OP_UPDATE, 12'hAAA, 32'sd0, 32'sd0, -32'sd123456, 32'sd987654},
          1'b0, 32'sd0, 32'sd0},
        '{ALPHA_MIN, '{OP_LOAD, 12'd2, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
          1'b1, 32'sd0, 32'sd0},
        '{ALPHA_MIN, '{OP_UPDATE, 12'd2, 32'sd0, 32'sd0, 32'sd1, -32'sd1},
          1'b1, -32'sd1, 32'sd1},
        '{ALPHA_MIN, '{OP_LOAD, 12'd6, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX},
          1'b1, SAMPLE_MAX, SAMPLE_MIN},
        '{ALPHA_MIN, '{OP_UPDATE, 12'd6, 32'sd0, 32'sd0, SAMPLE_MIN, SAMPLE_MAX},
          1'b0, 32'sd0, 32'sd0},
        '{ALPHA_MIN, '{OP_UPDATE, 12'd6, 32'sd0, 32'sd0, SAMPLE_MAX, SAMPLE_MIN},
          1'b0, 32'sd0, 32'sd0},
        '{ALPHA_MIN, '{OP_UPDATE, 12'd4095, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
          1'b0, 32'sd0, 32'sd0},
        '{16'sd1, '{OP_LOAD, 12'd3, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
          1'b1, 32'sd0, 32'sd0},
        '{16'sd1, '{OP_UPDATE, 12'd3, 32'sd0, 32'sd0, 32'sd16384, -32'sd16384},
          1'b1, 32'sd1, 32'sd0},
        '{16'sd1, '{OP_LOAD, 12'd5, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
          1'b1, 32'sd0, 32'sd0},
        '{16'sd1, '{OP_UPDATE, 12'd5, 32'sd0, 32'sd0, 32'sd16383, -32'sd16385},
          1'b1, 32'sd0, -32'sd1},
        '{16'sd1, '{OP_LOAD, 12'h555, 32'sh7FFF0000, -32'sd65536, 32'sd12345, -32'sd777},
          1'b1, 32'sh7FFF0000, -32'sd65536},
        '{16'sd1, '{OP_UPDATE, 12'h555, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
          1'b0, 32'sd0, 32'sd0}
    };

    absorbing_boundary_update u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("absorbing_boundary_update regression: fail");
        $finish;
    end

    // new = old_inner + round(alpha * (inner - old_boundary)), saturated
    function automatic sample_t absorb_value(sample_t inr_new, sample_t bnd_old,
                                             sample_t inr_old, alpha_t a);
        longint diff;
        longint prod;
        longint sum;
        diff = longint'(inr_new) - longint'(bnd_old);
        prod = longint'(a) * diff;
        sum  = longint'(inr_old) + ((prod + ROUND_HALF) >>> FRAC_BITS);
        if (sum > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (sum < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return sample_t'(sum);
    endfunction

    function automatic void advance_history(bnd_item_t it);
        hist_t       h;
        bnd_result_t r;
        h = node_hist[it.node];
        r.node = it.node;
        if (it.op == OP_LOAD)
        begin
            r.p = it.bp;
            r.q = it.bq;
        end
        else
        begin
            r.p = absorb_value(it.ip, h.bnd_p, h.inr_p, alpha_q);
            r.q = absorb_value(it.iq, h.bnd_q, h.inr_q, alpha_q);
        end
        node_hist[it.node]   = '{bnd_p: r.p, bnd_q: r.q, inr_p: it.ip, inr_q: it.iq};
        node_loaded[it.node] = 1'b1;
        boundary_due.push_back(r);
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'($urandom_range(0, 65535)) - 32'sd32768;
            3:       return sample_t'($urandom_range(0, 2)) - 32'sd1;
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // called at a rising edge; returns at the edge that takes the item
    task automatic send_item(bnd_item_t it, logic chk, sample_t ep, sample_t eq);
        din_if.valid      <= 1'b1;
        din_if.op         <= it.op;
        din_if.node       <= it.node;
        din_if.boundary_p <= it.bp;
        din_if.boundary_q <= it.bq;
        din_if.inner_p    <= it.ip;
        din_if.inner_q    <= it.iq;
        do
            @(negedge clk);
        while (!din_if.ready);
        advance_history(it);
        if (chk)
            boundary_due[boundary_due.size()-1] = '{node: it.node, p: ep, q: eq};
        @(posedge clk);
    endtask

    task automatic sender_gap(int n);
        din_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic settle();
        din_if.valid <= 1'b0;
        while (boundary_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // setup and access phases, then psel is dropped before the next transfer
    task automatic apb_xfer(logic wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (wr && addr[ADDR_W-1:2] == REG_ALPHA)
            alpha_q = alpha_t'(wdata[ALPHA_W-1:0]);
        @(posedge clk);
    endtask

    // write alpha, poke the unused slot, read alpha back
    task automatic set_alpha(alpha_t a);
        logic [DATA_W-1:0] rd;
        apb_xfer(1'b1, {REG_ALPHA, 2'b00}, {16'($urandom()), a}, rd);
        apb_xfer(1'b1, {REG_UNUSED, 2'b00}, DATA_W'($urandom()), rd);
        apb_xfer(1'b0, {REG_ALPHA, 2'b00}, '0, rd);
        check_field("alpha", longint'(alpha_q), longint'(alpha_t'(rd[ALPHA_W-1:0])));
    endtask

    initial
    begin : rx_proc
        int stall;
        stall = 0;
        dout_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && n_results >= HOLD_AT)
            begin
                hold_done = 1'b1;
                stall     = HOLD_CYC;
            end
            if (stall == 0 && rx_idle && !tail_mode && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 19);
            if (stall > 0)
            begin
                dout_if.ready <= 1'b0;
                stall--;
            end
            else
                dout_if.ready <= 1'b1;
        end
    end

    always @(negedge clk)
    begin : result_check
        bnd_result_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            n_results++;
            if (boundary_due.size() == 0)
            begin
                $error("unexpected result for node %0d", dout_if.node_out);
                n_errors++;
            end
            else
            begin
                want = boundary_due.pop_front();
                check_field("node_out", longint'(want.node), longint'(dout_if.node_out));
                check_field("new_boundary_p", longint'(want.p),
                            longint'(dout_if.new_boundary_p));
                check_field("new_boundary_q", longint'(want.q),
                            longint'(dout_if.new_boundary_q));
            end
        end
    end

    initial
    begin : stimulus
        bnd_item_t it;
        alpha_t    a;
        node_t     node_pool [POOL_SIZE];
        bit        tx_idle;
        int        k;
        int        ph;

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        din_if.valid      <= 1'b0;
        din_if.op         <= OP_LOAD;
        din_if.node       <= '0;
        din_if.boundary_p <= '0;
        din_if.boundary_q <= '0;
        din_if.inner_p    <= '0;
        din_if.inner_q    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_rows[k].alpha != alpha_q)
            begin
                settle();
                set_alpha(dir_rows[k].alpha);
            end
            send_item(dir_rows[k].item, dir_rows[k].chk, dir_rows[k].ep, dir_rows[k].eq);
        end

        node_pool[0] = '0;
        node_pool[1] = node_t'(NODES - 1);
        for (k = 2; k < POOL_SIZE; k++)
            node_pool[k] = node_t'($urandom_range(0, NODES - 1));

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            tail_mode = (ph == PHASES - 1);
            tx_idle   = (ph == 0 || ph == 2 || ph == 3);
            rx_idle   = (ph != 2);
            case (ph)
                0:       a = ALPHA_MAX;
                1:       a = ALPHA_MIN;
                3:       a = ALPHA_ZERO;
                default: a = alpha_t'($urandom_range(0, 65535));
            endcase
            set_alpha(a);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // sender waits out every pending result once
                if (ph == 2 && k == PHASE_ITEMS / 2)
                    settle();
                if ($urandom_range(0, 6) == 0)
                    it.node = node_t'($urandom_range(0, NODES - 1));
                else
                    it.node = node_pool[$urandom_range(0, POOL_SIZE - 1)];
                // never update a node whose history was not loaded
                if (!node_loaded[it.node] || $urandom_range(0, 3) == 0)
                    it.op = OP_LOAD;
                else
                    it.op = OP_UPDATE;
                it.bp = rand_sample();
                it.bq = rand_sample();
                it.ip = rand_sample();
                it.iq = rand_sample();
                send_item(it, 1'b0, '0, '0);
                if (tx_idle && !tail_mode && $urandom_range(0, 4) == 0)
                    sender_gap($urandom_range(1, 19));
            end
        end

        settle();
        if (n_errors == 0)
            $display("absorbing_boundary_update regression: pass");
        else
            $display("absorbing_boundary_update regression: fail");
        $finish;
    end

endmodule
